FILE: src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and result codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [1:0] kind_t;
  typedef logic [1:0] err_t;
  typedef logic [3:0] opcode_t;

  // Result kinds
  localparam kind_t KIND_DATA  = 2'd0;
  localparam kind_t KIND_EMPTY = 2'd1;
  localparam kind_t KIND_ERROR = 2'd2;

  // Error codes
  localparam err_t ERR_NONE     = 2'd0;
  localparam err_t ERR_NO_MASK  = 2'd1;
  localparam err_t ERR_TOO_BIG  = 2'd2;

  // Header decode
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // Reset value of the extended length limit
  localparam logic [15:0] MAX_EXT_RESET = 16'd131;

endpackage

FILE: src/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd_in_if / wsd_out_if
// Valid/ready channels: received bytes in, deframed results out.
// ----------------------------------------------------------------------------
interface wsd_in_if
  import wsd_pkg::*;
;
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface wsd_out_if
  import wsd_pkg::*;
;
  logic    valid;
  logic    ready;
  kind_t   kind;
  byte_t   data;
  opcode_t opcode;
  logic    fin;
  logic    last;
  err_t    error_code;

  modport source (output valid, output kind, output data, output opcode, output fin,
                  output last, output error_code, input ready);
  modport sink   (input valid, input kind, input data, input opcode, input fin,
                  input last, input error_code, output ready);
endinterface

FILE: src/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Parses client-to-server WebSocket frames one byte per transaction and
// emits unmasked payload bytes, empty-frame markers and sticky errors.
// ----------------------------------------------------------------------------
//
//  channel  | direction | payload                                  | handshake
//  ---------+-----------+------------------------------------------+----------
//  in_bus   | in        | in_byte                                  | valid/ready
//  out_bus  | out       | kind, data, opcode, fin, last, error_code | valid/ready
//  cfg_*    | in        | cfg_wdata (max_ext_payload)              | cfg_we only
//
//  One byte is taken per clock while in_bus.ready is high. Its result
//  (at most one) appears in the output register on the following cycle.
//  in_bus.ready = output register empty or being drained this cycle, so a
//  stalled output holds exactly one result and blocks further input.
//  rst_n is synchronous, active low; it clears the parser and the sticky
//  error and restores the extended length limit to 131.
//
// Frame layout consumed:
//   hdr0: fin[7], opcode[3:0]
//   hdr1: mask[7] (must be 1), len code[6:0]; 127 -> too big, 126 -> ext16
//   ext hi / ext lo: 16-bit big-endian length, checked against the limit
//   4 mask bytes, then payload bytes XORed with mask[index mod 4]
// ----------------------------------------------------------------------------
module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  wsd_in_if.sink           in_bus,
  wsd_out_if.source        out_bus,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  localparam int LW = LENGTH_WIDTH;
  // Largest length LENGTH_WIDTH bits can hold, as a 16-bit value
  localparam logic [15:0] LEN_MAX = 16'((32'd1 << LW) - 32'd1);

  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_HDR1  = 3'd1,
    PH_EXTHI = 3'd2,
    PH_EXTLO = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  // Parser state
  phase_t          phase_r, phase_nxt;
  logic [LW-1:0]   byte_index_r, byte_index_nxt;
  logic [LW-1:0]   payload_length_r, payload_length_nxt;
  logic [31:0]     mask_key_r, mask_key_nxt;
  opcode_t         frame_opcode_r, frame_opcode_nxt;
  logic            frame_fin_r, frame_fin_nxt;
  logic            sticky_r, sticky_nxt;
  logic [15:0]     max_ext_r;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  kind_t           out_kind_r, out_kind_nxt;
  byte_t           out_data_r, out_data_nxt;
  logic            out_last_r, out_last_nxt;
  err_t            out_err_r, out_err_nxt;

  logic            take_in;
  logic            has_res;
  byte_t           b;
  logic [15:0]     ext_len;
  byte_t           mask_byte;
  logic            data_last;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign take_in      = in_bus.valid && in_bus.ready;
  assign b            = in_bus.in_byte;

  // Extended length: high byte parked in the low bits of payload_length
  assign ext_len   = {payload_length_r[7:0], b};
  // Last payload byte when index + 1 reaches the length
  assign data_last = ({1'b0, byte_index_r} + (LW+1)'(1)) >= {1'b0, payload_length_r};

  always_comb begin
    case (byte_index_r[1:0])
      2'd0:    mask_byte = mask_key_r[31:24];
      2'd1:    mask_byte = mask_key_r[23:16];
      2'd2:    mask_byte = mask_key_r[15:8];
      default: mask_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt          = phase_r;
    byte_index_nxt     = byte_index_r;
    payload_length_nxt = payload_length_r;
    mask_key_nxt       = mask_key_r;
    frame_opcode_nxt   = frame_opcode_r;
    frame_fin_nxt      = frame_fin_r;
    sticky_nxt         = sticky_r;
    has_res            = 1'b0;
    out_kind_nxt       = out_kind_r;
    out_data_nxt       = out_data_r;
    out_last_nxt       = out_last_r;
    out_err_nxt        = out_err_r;

    if (take_in && !sticky_r) begin
      case (phase_r)
        PH_HDR1: begin
          if (!b[7]) begin
            sticky_nxt   = 1'b1;
            phase_nxt    = PH_HDR0;
            has_res      = 1'b1;
            out_kind_nxt = KIND_ERROR;
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
            out_err_nxt  = ERR_NO_MASK;
          end else if (b[6:0] == LEN_CODE_EXT64) begin
            sticky_nxt   = 1'b1;
            phase_nxt    = PH_HDR0;
            has_res      = 1'b1;
            out_kind_nxt = KIND_ERROR;
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
            out_err_nxt  = ERR_TOO_BIG;
          end else begin
            byte_index_nxt = '0;
            if (b[6:0] == LEN_CODE_EXT16) begin
              payload_length_nxt = '0;
              phase_nxt          = PH_EXTHI;
            end else begin
              payload_length_nxt = LW'(b[6:0]);
              mask_key_nxt       = '0;
              phase_nxt          = PH_MASK;
            end
          end
        end
        PH_EXTHI: begin
          payload_length_nxt = LW'(b);
          phase_nxt          = PH_EXTLO;
        end
        PH_EXTLO: begin
          if (ext_len > max_ext_r || ext_len > LEN_MAX) begin
            sticky_nxt   = 1'b1;
            phase_nxt    = PH_HDR0;
            has_res      = 1'b1;
            out_kind_nxt = KIND_ERROR;
            out_data_nxt = '0;
            out_last_nxt = 1'b1;
            out_err_nxt  = ERR_TOO_BIG;
          end else begin
            payload_length_nxt = LW'(ext_len);
            byte_index_nxt     = '0;
            mask_key_nxt       = '0;
            phase_nxt          = PH_MASK;
          end
        end
        PH_MASK: begin
          mask_key_nxt = {mask_key_r[23:0], b};
          if (byte_index_r[1:0] != 2'd3) begin
            byte_index_nxt = byte_index_r + LW'(1);
          end else begin
            byte_index_nxt = '0;
            if (payload_length_r == '0) begin
              phase_nxt    = PH_HDR0;
              has_res      = 1'b1;
              out_kind_nxt = KIND_EMPTY;
              out_data_nxt = '0;
              out_last_nxt = 1'b1;
              out_err_nxt  = ERR_NONE;
            end else begin
              phase_nxt = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          has_res      = 1'b1;
          out_kind_nxt = KIND_DATA;
          out_data_nxt = b ^ mask_byte;
          out_last_nxt = data_last;
          out_err_nxt  = ERR_NONE;
          if (data_last) begin
            phase_nxt      = PH_HDR0;
            byte_index_nxt = '0;
          end else begin
            byte_index_nxt = byte_index_r + LW'(1);
          end
        end
        default: begin
          // header first byte; unused codes land here too
          frame_fin_nxt    = b[7];
          frame_opcode_nxt = b[3:0];
          phase_nxt        = PH_HDR1;
        end
      endcase
    end

    if (take_in) begin
      out_valid_nxt = has_res;
    end else begin
      out_valid_nxt = out_valid_r && !out_bus.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_HDR0;
      byte_index_r     <= '0;
      payload_length_r <= '0;
      mask_key_r       <= '0;
      frame_opcode_r   <= '0;
      frame_fin_r      <= 1'b0;
      sticky_r         <= 1'b0;
      max_ext_r        <= MAX_EXT_RESET;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      byte_index_r     <= byte_index_nxt;
      payload_length_r <= payload_length_nxt;
      mask_key_r       <= mask_key_nxt;
      frame_opcode_r   <= frame_opcode_nxt;
      frame_fin_r      <= frame_fin_nxt;
      sticky_r         <= sticky_nxt;
      out_valid_r      <= out_valid_nxt;
      if (cfg_we) begin
        max_ext_r <= cfg_wdata;
      end
    end
    if (has_res) begin
      out_kind_r <= out_kind_nxt;
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_err_r  <= out_err_nxt;
    end
  end

  // Frame header fields change only on hdr0, which never yields a result,
  // so the live registers are valid for the held result.
  assign out_bus.valid      = out_valid_r;
  assign out_bus.kind       = out_kind_r;
  assign out_bus.data       = out_data_r;
  assign out_bus.opcode     = frame_opcode_r;
  assign out_bus.fin        = frame_fin_r;
  assign out_bus.last       = out_last_r;
  assign out_bus.error_code = out_err_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r |=> sticky_r)
    else $error("sticky error cleared without reset");

  a_error_sets_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_ERROR) |-> sticky_r)
    else $error("error result without sticky error");

  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == KIND_EMPTY || out_kind_r == KIND_ERROR))
      |-> (out_last_r && out_data_r == '0))
    else $error("empty/error result must be last with zero data");

  a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (payload_length_r != '0 && byte_index_r < payload_length_r))
    else $error("payload index out of range");

endmodule
